// ===== sv/trp_pkg.sv =====
// trp_pkg: shared types and constants for the touch report frame parser
// holds the result kind codes, field widths and the event and result structs
// no dependencies
package trp_pkg;

  localparam int HDR_LEN = 4;
  localparam int REC_PAYLOAD = 6;
  localparam int POS_W = 3;
  localparam int SLOT_W = 4;
  localparam int BIR_W = 3;
  localparam int ROW_W = 5;
  localparam int COL_W = 6;
  localparam int REC_W = 8 * REC_PAYLOAD;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_TOUCH  = 2'd1,
    KIND_CELL   = 2'd2
  } kind_t;

  // what the current beat causes, before formatting
  typedef struct packed {
    logic              emit;
    kind_t             kind;
    logic [7:0]        hdr_hi;
    logic [7:0]        hdr_mid;
    logic [REC_W-1:0]  rec;
    logic [SLOT_W-1:0] slot;
    logic [3:0]        tcount;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
    logic [7:0]        data;
  } trp_evt_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] header_word;
    logic [3:0]  touch_id;
    logic [13:0] x_raw;
    logic [13:0] y_raw;
    logic [7:0]  touch_area;
    logic [7:0]  touch_intensity;
    logic [3:0]  valid_touches;
    logic [4:0]  cell_row;
    logic [5:0]  cell_col;
    logic [6:0]  cell_value;
    logic        last_of_frame;
  } trp_result_t;

endpackage

// ===== sv/touch_report_frame_parser_unit.sv =====
// touch_report_frame_parser_unit: top level of the touch report frame parser
// depends on trp_pkg, trp_tracker and trp_format
//
// Input channel: in_valid/in_ready carry one frame byte a beat (data_byte),
// with frame_start marking header byte 0 of a new frame. Output channel:
// out_valid/out_ready carry one result a beat: a header after header byte 3,
// a touch point after byte 6 of a record whose valid bit is set, and a cell
// for every matrix byte, the final one flagged by last_of_frame.
// Each result is registered, so it appears in the cycle after the byte that causes it.
// Throughput: one byte a cycle while results are taken; the position counters
// and field logic sit between the input port and a single result register.
// A new byte is taken while the result register is empty or being drained,
// so while the receiver stalls a held result stops the input until it is taken.
// Reset clears all position counters and empties the result register: the
// first byte after reset is header byte 0.
module touch_report_frame_parser_unit import trp_pkg::*; #(
  parameter int MATRIX_ROWS = 22,
  parameter int MATRIX_COLS = 36,
  parameter int TOUCH_SLOTS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [23:0] header_word,
  output logic [3:0]  touch_id,
  output logic [13:0] x_raw,
  output logic [13:0] y_raw,
  output logic [7:0]  touch_area,
  output logic [7:0]  touch_intensity,
  output logic [3:0]  valid_touches,
  output logic [4:0]  cell_row,
  output logic [5:0]  cell_col,
  output logic [6:0]  cell_value,
  output logic        last_of_frame
);

  logic        accept;
  trp_evt_t    evt;
  trp_result_t res, res_q;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  trp_tracker #(
    .MATRIX_ROWS(MATRIX_ROWS),
    .MATRIX_COLS(MATRIX_COLS),
    .TOUCH_SLOTS(TOUCH_SLOTS)
  ) u_tracker (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .data_byte(data_byte),
    .frame_start(frame_start),
    .evt(evt)
  );

  trp_format u_format (
    .evt(evt),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= evt.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && evt.emit) begin
      res_q <= res;
    end
  end

  assign kind            = res_q.kind;
  assign header_word     = res_q.header_word;
  assign touch_id        = res_q.touch_id;
  assign x_raw           = res_q.x_raw;
  assign y_raw           = res_q.y_raw;
  assign touch_area      = res_q.touch_area;
  assign touch_intensity = res_q.touch_intensity;
  assign valid_touches   = res_q.valid_touches;
  assign cell_row        = res_q.cell_row;
  assign cell_col        = res_q.cell_col;
  assign cell_value      = res_q.cell_value;
  assign last_of_frame   = res_q.last_of_frame;

  a_touch_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_TOUCH |-> valid_touches != 4'd0 && touch_id != 4'd0)
    else $error("touch result without a slot or count");

  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |->
      kind == KIND_CELL && cell_row == 5'(MATRIX_ROWS - 1) &&
      cell_col == 6'(MATRIX_COLS - 1))
    else $error("end of frame away from the final cell");

  a_cell_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_CELL |-> cell_value <= 7'd100)
    else $error("scaled cell value out of range");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(cell_col))
    else $error("stalled result lost or changed");

endmodule

// ===== sv/trp_tracker.sv =====
// trp_tracker: frame position counters, header and record holding registers
// decodes where each beat falls in the frame; depends on trp_pkg
module trp_tracker import trp_pkg::*; #(
  parameter int MATRIX_ROWS = 22,
  parameter int MATRIX_COLS = 36,
  parameter int TOUCH_SLOTS = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  output trp_evt_t   evt
);

  logic [POS_W-1:0]  pos, pos_e, pos_next;
  logic [15:0]       hdr_hold, hdr_hold_next;
  logic [REC_W-1:0]  rec_hold, rec_hold_next;
  logic [SLOT_W-1:0] rec_idx, rec_idx_e, rec_idx_next;
  logic [BIR_W-1:0]  bir, bir_e, bir_next;
  logic [3:0]        tcount, tcount_e, tcount_next;
  logic [ROW_W-1:0]  row, row_e, row_next;
  logic [COL_W-1:0]  col, col_e, col_next;
  logic              row_end, col_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      rec_idx <= '0;
      bir     <= '0;
      tcount  <= '0;
      row     <= '0;
      col     <= '0;
    end else if (accept) begin
      pos     <= pos_next;
      rec_idx <= rec_idx_next;
      bir     <= bir_next;
      tcount  <= tcount_next;
      row     <= row_next;
      col     <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_hold <= hdr_hold_next;
      rec_hold <= rec_hold_next;
    end
  end

  always_comb begin
    // frame start restarts every counter before the beat is placed
    pos_e     = frame_start ? '0 : pos;
    rec_idx_e = frame_start ? '0 : rec_idx;
    bir_e     = frame_start ? '0 : bir;
    tcount_e  = frame_start ? '0 : tcount;
    row_e     = frame_start ? '0 : row;
    col_e     = frame_start ? '0 : col;

    row_end = ({1'b0, row_e} + 6'd1) >= 6'(MATRIX_ROWS);
    col_end = ({1'b0, col_e} + 7'd1) >= 7'(MATRIX_COLS);

    pos_next      = pos_e;
    hdr_hold_next = hdr_hold;
    rec_hold_next = rec_hold;
    rec_idx_next  = rec_idx_e;
    bir_next      = bir_e;
    tcount_next   = tcount_e;
    row_next      = row_e;
    col_next      = col_e;

    evt        = '0;
    evt.kind   = KIND_HEADER;
    evt.hdr_hi = hdr_hold[15:8];
    evt.hdr_mid = hdr_hold[7:0];
    evt.rec    = rec_hold;
    evt.slot   = rec_idx_e;
    evt.row    = row_e;
    evt.col    = col_e;
    evt.data   = data_byte;

    if (pos_e < POS_W'(HDR_LEN)) begin
      pos_next = pos_e + POS_W'(1);
      if (pos_e == POS_W'(0)) begin
        hdr_hold_next[15:8] = data_byte;
      end else if (pos_e == POS_W'(2)) begin
        hdr_hold_next[7:0] = data_byte;
      end else if (pos_e == POS_W'(3)) begin
        evt.emit = 1'b1;
        evt.kind = KIND_HEADER;
      end
    end else if (rec_idx_e < SLOT_W'(TOUCH_SLOTS)) begin
      if (bir_e < BIR_W'(REC_PAYLOAD)) begin
        for (int i = 0; i < REC_PAYLOAD; i++) begin
          if (bir_e == BIR_W'(i)) begin
            rec_hold_next[8*i +: 8] = data_byte;
          end
        end
        bir_next = bir_e + BIR_W'(1);
      end else begin
        rec_idx_next = rec_idx_e + SLOT_W'(1);
        bir_next     = '0;
        if (rec_hold[7]) begin
          tcount_next = tcount_e + 4'd1;
          evt.emit    = 1'b1;
          evt.kind    = KIND_TOUCH;
          evt.tcount  = tcount_e + 4'd1;
        end
      end
    end else begin
      evt.emit = 1'b1;
      evt.kind = KIND_CELL;
      evt.last = row_end && col_end;
      if (row_end && col_end) begin
        pos_next     = '0;
        rec_idx_next = '0;
        bir_next     = '0;
        tcount_next  = '0;
        row_next     = '0;
        col_next     = '0;
      end else if (col_end) begin
        col_next = '0;
        row_next = row_e + ROW_W'(1);
      end else begin
        col_next = col_e + COL_W'(1);
      end
    end
  end

endmodule

// ===== sv/trp_format.sv =====
// trp_format: builds the result fields from a decoded beat, scales cell bytes
// fields outside the result kind are zero; depends on trp_pkg
module trp_format import trp_pkg::*; (
  input  trp_evt_t    evt,
  output trp_result_t res
);

  logic [14:0] prod;
  logic [15:0] acc;

  always_comb begin
    // byte*100, then /255 as (p + p/256 + 1)/256, exact for 15-bit p
    prod = {1'b0, evt.data, 6'd0} + {2'b0, evt.data, 5'd0} + {5'b0, evt.data, 2'd0};
    acc  = {1'b0, prod} + {9'b0, prod[14:8]} + 16'd1;

    res      = '0;
    res.kind = evt.kind;
    unique case (evt.kind)
      KIND_HEADER: begin
        res.header_word = {evt.hdr_hi, evt.hdr_mid, evt.data};
      end
      KIND_TOUCH: begin
        res.touch_id        = evt.slot + 4'd1;
        res.x_raw           = {evt.rec[5:0], evt.rec[15:8]};
        res.y_raw           = {evt.rec[21:16], evt.rec[31:24]};
        res.touch_area      = evt.rec[39:32];
        res.touch_intensity = evt.rec[47:40];
        res.valid_touches   = evt.tcount;
      end
      KIND_CELL: begin
        res.cell_row      = evt.row;
        res.cell_col      = evt.col;
        res.cell_value    = acc[14:8];
        res.last_of_frame = evt.last;
      end
      default: begin
        res.kind = KIND_HEADER;
      end
    endcase
  end

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for touch_report_frame_parser_unit
// holds the byte driver, result monitor and a bit-true frame parser predictor
// depends on trp_pkg and touch_report_frame_parser_unit
`timescale 1ns / 1ps

module tb_top;
  import trp_pkg::*;

  localparam int ROWS = 22;
  localparam int COLS = 36;
  localparam int SLOTS = 10;
  localparam int HDR_BYTES = 4;
  localparam int REC_BYTES = 7;
  localparam int RECORDS_END = HDR_BYTES + SLOTS * REC_BYTES;
  localparam int FRAME_BYTES = RECORDS_END + ROWS * COLS;
  localparam int MAX_IDLE = 17;

  typedef struct {
    logic [7:0] data;
    logic       start;
    int         gap;
    bit         drain;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [23:0] header_word;
  logic [3:0]  touch_id;
  logic [13:0] x_raw;
  logic [13:0] y_raw;
  logic [7:0]  touch_area;
  logic [7:0]  touch_intensity;
  logic [3:0]  valid_touches;
  logic [4:0]  cell_row;
  logic [5:0]  cell_col;
  logic [6:0]  cell_value;
  logic        last_of_frame;

  frame_byte_t byte_queue[$];
  trp_result_t awaited_results[$];

  // predictor state
  int         hdr_pos;
  logic [7:0] hdr_first;
  logic [7:0] hdr_second;
  logic [7:0] rec_bytes[0:5];
  int         slot;
  int         rec_pos;
  int         seen_touches;
  int         mat_row;
  int         mat_col;

  int errors = 0;
  int bytes_taken = 0;
  int n_headers = 0;
  int n_touches = 0;
  int n_cells = 0;
  int n_frames_done = 0;
  int n_restarts = 0;
  int n_noise = 0;
  bit burst = 1'b0;
  bit calm = 1'b0;
  int idle_left = 0;
  bit armed = 1'b0;
  int stall_left = 0;

  always #4 clk = ~clk;

  touch_report_frame_parser_unit #(
    .MATRIX_ROWS(ROWS),
    .MATRIX_COLS(COLS),
    .TOUCH_SLOTS(SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .header_word(header_word),
    .touch_id(touch_id),
    .x_raw(x_raw),
    .y_raw(y_raw),
    .touch_area(touch_area),
    .touch_intensity(touch_intensity),
    .valid_touches(valid_touches),
    .cell_row(cell_row),
    .cell_col(cell_col),
    .cell_value(cell_value),
    .last_of_frame(last_of_frame)
  );

  task automatic restart_frame();
    hdr_pos = 0;
    hdr_first = 8'h00;
    hdr_second = 8'h00;
    for (int i = 0; i < 6; i++) rec_bytes[i] = 8'h00;
    slot = 0;
    rec_pos = 0;
    seen_touches = 0;
    mat_row = 0;
    mat_col = 0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic s);
    trp_result_t res;
    int scaled;
    res = '0;
    if (s) restart_frame();
    if (hdr_pos < HDR_BYTES) begin
      case (hdr_pos)
        0: hdr_first = b;
        2: hdr_second = b;
        3: begin
          res.kind = KIND_HEADER;
          res.header_word = {hdr_first, hdr_second, b};
          awaited_results.push_back(res);
          n_headers++;
        end
        default: ;
      endcase
      hdr_pos++;
    end else if (slot < SLOTS) begin
      if (rec_pos < 6) begin
        rec_bytes[rec_pos] = b;
        rec_pos++;
      end else begin
        if (rec_bytes[0][7]) begin
          seen_touches = (seen_touches + 1) % 16;
          res.kind = KIND_TOUCH;
          res.touch_id = 4'(slot + 1);
          res.x_raw = {rec_bytes[0][5:0], rec_bytes[1]};
          res.y_raw = {rec_bytes[2][5:0], rec_bytes[3]};
          res.touch_area = rec_bytes[4];
          res.touch_intensity = rec_bytes[5];
          res.valid_touches = 4'(seen_touches);
          awaited_results.push_back(res);
          n_touches++;
        end
        slot++;
        rec_pos = 0;
      end
    end else begin
      scaled = (int'(b) * 100) / 255;
      res.kind = KIND_CELL;
      res.cell_row = 5'(mat_row);
      res.cell_col = 6'(mat_col);
      res.cell_value = scaled[6:0];
      res.last_of_frame = (mat_row + 1 >= ROWS) && (mat_col + 1 >= COLS);
      awaited_results.push_back(res);
      n_cells++;
      if (res.last_of_frame) begin
        restart_frame();
        n_frames_done++;
      end else if (mat_col + 1 >= COLS) begin
        mat_col = 0;
        mat_row++;
      end else begin
        mat_col++;
      end
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input logic s, input bit d);
    frame_byte_t item;
    item.data = b;
    item.start = s;
    item.gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
    item.drain = d;
    byte_queue.push_back(item);
  endtask

  // well-formed frame, stopped after cut bytes
  task automatic add_frame(input int cut, input bit restart, input bit d);
    logic [7:0] b;
    bit all_valid;
    all_valid = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < cut && i < FRAME_BYTES; i++) begin
      b = 8'($urandom);
      if (i >= HDR_BYTES && i < RECORDS_END) begin
        if ((i - HDR_BYTES) % REC_BYTES == 0)
          b[7] = all_valid || ($urandom_range(0, 2) != 0);
      end else if (i >= RECORDS_END) begin
        case ($urandom_range(0, 7))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: ;
        endcase
      end
      add_byte(b, restart && (i == 0), d && (i == 0));
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : driver
    frame_byte_t nxt;
    logic valid_next;
    if (rst) begin
      in_valid <= 1'b0;
      restart_frame();
      armed = 1'b0;
    end else begin
      valid_next = in_valid;
      if (in_valid && in_ready) begin
        parse_byte(data_byte, frame_start);
        bytes_taken++;
        valid_next = 1'b0;
      end
      if (!valid_next && byte_queue.size() > 0) begin
        if (!armed) begin
          idle_left = byte_queue[0].gap;
          armed = 1'b1;
        end
        if (idle_left > 0) begin
          idle_left--;
        end else if (!byte_queue[0].drain || awaited_results.size() == 0) begin
          nxt = byte_queue.pop_front();
          data_byte <= nxt.data;
          frame_start <= nxt.start;
          valid_next = 1'b1;
          armed = 1'b0;
        end
      end
      in_valid <= valid_next;
    end
  end

  always @(posedge clk) begin : monitor
    trp_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: result beat expected none actual kind %0d", $time, kind);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", want.kind, kind);
          check_field("header_word", want.header_word, header_word);
          check_field("touch_id", want.touch_id, touch_id);
          check_field("x_raw", want.x_raw, x_raw);
          check_field("y_raw", want.y_raw, y_raw);
          check_field("touch_area", want.touch_area, touch_area);
          check_field("touch_intensity", want.touch_intensity, touch_intensity);
          check_field("valid_touches", want.valid_touches, valid_touches);
          check_field("cell_row", want.cell_row, cell_row);
          check_field("cell_col", want.cell_col, cell_col);
          check_field("cell_value", want.cell_value, cell_value);
          check_field("last_of_frame", want.last_of_frame, last_of_frame);
        end
        if ($urandom_range(0, 29) == 0) calm = ~calm;
        stall_left = calm ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  initial begin
    int short_bytes;
    int cut;
    int len;
    short_bytes = 0;

    // directed: header and record extremes, invalid record, restart mid-frame
    add_byte(8'h00, 1'b1, 1'b0); add_byte(8'hFF, 1'b0, 1'b0); add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0); add_byte(8'hFF, 1'b0, 1'b0); add_byte(8'hC0, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0); add_byte(8'hFF, 1'b0, 1'b0); add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h55, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h80, 1'b1, 1'b0); add_byte(8'h00, 1'b0, 1'b0); add_byte(8'h3F, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0); add_byte(8'h00, 1'b0, 1'b0); add_byte(8'h3F, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0); add_byte(8'h00, 1'b0, 1'b0); add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    n_restarts++;

    // two whole frames, the second relying on the wrap after the last cell
    burst = 1'b0;
    add_frame(FRAME_BYTES, 1'b1, 1'b1);
    burst = 1'b1;
    add_frame(FRAME_BYTES, 1'b0, 1'b1);

    while (short_bytes < 600) begin
      burst = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0: begin
          len = $urandom_range(1, 20);
          for (int i = 0; i < len; i++)
            add_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b0);
          n_noise += len;
          cut = 0;
        end
        1: cut = $urandom_range(1, HDR_BYTES + 1);
        8, 9: cut = $urandom_range(RECORDS_END, FRAME_BYTES - 1);
        default: cut = $urandom_range(HDR_BYTES, RECORDS_END + 30);
      endcase
      if (cut > 0) begin
        add_frame(cut, 1'b1, $urandom_range(0, 5) == 0);
        short_bytes += cut;
        n_restarts++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (byte_queue.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d bytes in: %0d headers, %0d touch points, %0d cells, %0d frames completed",
             bytes_taken, n_headers, n_touches, n_cells, n_frames_done);
    $display("%0d frames cut short by a restart, %0d bytes of line noise",
             n_restarts, n_noise);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timed out with %0d results outstanding", awaited_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
sv/trp_pkg.sv
sv/trp_tracker.sv
sv/trp_format.sv
sv/touch_report_frame_parser_unit.sv
bench/tb_top.sv
